// ===== design/gtg_pkg.sv =====
`timescale 1ns / 1ps
package gtg_pkg;
   localparam int CordicStepsDefault = 16;
   localparam int AngW = 40;
   localparam logic signed [AngW-1:0] AngPi = 40'sd205887;
   localparam logic signed [AngW-1:0] AngTwoPi = 40'sd411775;
   localparam logic signed [AngW-1:0] AngHalfPi = 40'sd102944;
   localparam logic [23:0] SpeedMax = 24'hFFFFFF;
   localparam logic [23:0] SpeedCapRst = 24'd327680;
   localparam logic [23:0] ArriveRst = 24'd32768;
   localparam logic [15:0] GainRst = 16'd8192;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_GOAL = 2'd1,
      CMD_START = 2'd2,
      CMD_STOP = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_SPEED_CAP = 2'd0,
      CSR_ARRIVE = 2'd1,
      CSR_GAIN = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic drive_valid;
      logic [23:0] linear_speed;
      logic signed [15:0] angular_rate;
      logic navigating;
   } rsp_type;

   // work item from front to back
   typedef struct packed {
      logic compute;
      rsp_type imm;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
      logic signed [15:0] qw;
   } job_type;

   function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] i);
      logic signed [AngW-1:0] r;
      case (i)
         5'd0: r = 40'sd51472;
         5'd1: r = 40'sd30386;
         5'd2: r = 40'sd16055;
         5'd3: r = 40'sd8150;
         5'd4: r = 40'sd4091;
         5'd5: r = 40'sd2047;
         5'd6: r = 40'sd1024;
         5'd7: r = 40'sd512;
         5'd8: r = 40'sd256;
         5'd9: r = 40'sd128;
         5'd10: r = 40'sd64;
         5'd11: r = 40'sd32;
         5'd12: r = 40'sd16;
         5'd13: r = 40'sd8;
         5'd14: r = 40'sd4;
         5'd15: r = 40'sd2;
         5'd16: r = 40'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

// ===== design/gtg_if.sv =====
`timescale 1ns / 1ps
interface gtg_if #(parameter type T = logic);
   logic valid;
   logic ready;
   T data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

// ===== design/gtg_front.sv =====
`timescale 1ns / 1ps
module gtg_front (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input logic [1:0] in_cmd,
   input logic signed [31:0] in_pose_x,
   input logic signed [31:0] in_pose_y,
   input logic signed [15:0] in_qx,
   input logic signed [15:0] in_qy,
   input logic signed [15:0] in_qz,
   input logic signed [15:0] in_qw,
   input logic signed [31:0] in_tx,
   input logic signed [31:0] in_ty,
   output logic q_valid,
   input logic q_ready,
   output gtg_pkg::job_type q_job,
   input logic arrive_clr,
   input logic tick_done
);
   import gtg_pkg::*;
   localparam int Depth = 2;
   job_type mem_ff [Depth];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic nav_ff, nav_in, gv_ff, gv_in;
   logic signed [31:0] gx_ff, gx_in, gy_ff, gy_in;
   logic push, pop, emit;
   job_type job;
   cmd_type cmd;
   logic busy;
   logic [1:0] pend_ff, pend_in;

   assign cmd = cmd_type'(in_cmd);
   // flags lag while a tick is in the back end; hold input until it finishes
   assign busy = pend_ff != 2'd0;
   assign in_ready = (cnt_ff != 2'(Depth)) && !busy;
   assign q_valid = cnt_ff != 2'd0;
   assign q_job = mem_ff[rp_ff];
   assign pop = q_valid && q_ready;

   always_comb begin
      nav_in = nav_ff;
      gv_in = gv_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      emit = 1'b0;
      job = '0;
      job.dx = 33'(gx_ff) - 33'(in_pose_x);
      job.dy = 33'(gy_ff) - 33'(in_pose_y);
      job.qx = in_qx;
      job.qy = in_qy;
      job.qz = in_qz;
      job.qw = in_qw;
      if (arrive_clr) begin
         nav_in = 1'b0;
         gv_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         case (cmd)
            CMD_GOAL: begin
               gx_in = in_tx;
               gy_in = in_ty;
               gv_in = 1'b1;
               nav_in = 1'b1;
               emit = 1'b1;
               job.imm.navigating = 1'b1;
            end
            CMD_START: begin
               nav_in = 1'b1;
               emit = 1'b1;
               job.imm.navigating = 1'b1;
            end
            CMD_STOP: begin
               nav_in = 1'b0;
               gv_in = 1'b0;
               emit = 1'b1;
               job.imm.drive_valid = 1'b1;
            end
            default: begin
               emit = nav_ff && gv_ff;
               job.compute = 1'b1;
            end
         endcase
      end
   end

   assign push = emit;
   assign wp_in = push ? ~wp_ff : wp_ff;
   assign rp_in = pop ? ~rp_ff : rp_ff;
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);
   assign pend_in = pend_ff + 2'(push && job.compute) - 2'(tick_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
         pend_ff <= '0;
         nav_ff <= 1'b0;
         gv_ff <= 1'b0;
         gx_ff <= '0;
         gy_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
         pend_ff <= pend_in;
         nav_ff <= nav_in;
         gv_ff <= gv_in;
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
   end
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= job;
   end
endmodule

// ===== design/gtg_back.sv =====
`timescale 1ns / 1ps
module gtg_back #(
   parameter int CORDIC_STEPS = gtg_pkg::CordicStepsDefault
) (
   input logic clock,
   input logic reset,
   input logic j_valid,
   output logic j_ready,
   input gtg_pkg::job_type j_job,
   input logic [23:0] speed_cap,
   input logic [23:0] arrive_radius,
   input logic [15:0] heading_gain,
   output logic arrive_clr,
   output logic tick_done,
   output logic o_valid,
   input logic o_ready,
   output gtg_pkg::rsp_type o_rsp
);
   import gtg_pkg::*;
   localparam int Steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
   localparam int SW = $clog2(Steps + 1);
   localparam int VW = 52;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001, S_MUL = 8'b00000010, S_SQRT = 8'b00000100,
      S_PRE = 8'b00001000, S_ROT = 8'b00010000, S_ERR = 8'b00100000,
      S_RATE = 8'b01000000, S_OUT = 8'b10000000
   } st_type;

   st_type st_ff, st_in;
   job_type job_ff;
   logic big_ff;
   logic [49:0] sq_ff, rem_ff;
   logic [24:0] root_ff;
   logic [4:0] sqi_ff;
   logic [23:0] dist_ff;
   logic pass_ff; // 0 target, 1 yaw
   logic signed [VW-1:0] x_ff, y_ff;
   logic signed [AngW-1:0] z_ff, tgt_ff;
   logic [SW-1:0] it_ff;
   logic signed [AngW-1:0] err_ff;
   logic signed [AngW+16:0] prod_ff;
   rsp_type rsp_ff;
   logic ov_ff;

   logic [32:0] ax, ay;
   assign ax = j_job.dx[32] ? 33'(-j_job.dx) : 33'(j_job.dx);
   assign ay = j_job.dy[32] ? 33'(-j_job.dy) : 33'(j_job.dy);

   logic [32:0] bx, by;
   assign bx = job_ff.dx[32] ? 33'(-job_ff.dx) : 33'(job_ff.dx);
   assign by = job_ff.dy[32] ? 33'(-job_ff.dy) : 33'(job_ff.dy);

   assign j_ready = st_ff == S_IDLE && !ov_ff;
   assign o_valid = ov_ff;
   assign o_rsp = rsp_ff;
   assign arrive_clr = st_ff == S_PRE && !pass_ff && (dist_ff < arrive_radius);
   assign tick_done = arrive_clr || st_ff == S_OUT;

   // restoring sqrt, one result bit per cycle
   logic [49:0] trial;
   assign trial = 50'({rem_ff[47:0], sq_ff[49:48]}) - 50'({root_ff, 2'b01});

   logic signed [VW-1:0] xs, ys, yx, yy;
   logic signed [31:0] pyy, pzz, pwz, pxy;
   assign xs = x_ff >>> it_ff;
   assign ys = y_ff >>> it_ff;
   assign pyy = 32'(job_ff.qy) * 32'(job_ff.qy);
   assign pzz = 32'(job_ff.qz) * 32'(job_ff.qz);
   assign pwz = 32'(job_ff.qw) * 32'(job_ff.qz);
   assign pxy = 32'(job_ff.qx) * 32'(job_ff.qy);
   assign yx = VW'(33'sd1 <<< 30) - ((VW'(pyy) + VW'(pzz)) <<< 1);
   assign yy = (VW'(pwz) + VW'(pxy)) <<< 1;

   logic signed [AngW+16:0] rnd;
   assign rnd = (prod_ff + 57'sd32768) >>> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (o_valid && o_ready) ov_ff <= 1'b0;
         if (st_ff == S_IDLE && j_valid && j_ready && !j_job.compute) ov_ff <= 1'b1;
         if (st_ff == S_OUT) ov_ff <= 1'b1;
         if (arrive_clr) ov_ff <= 1'b1;
      end
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE: if (j_valid && j_ready && j_job.compute) st_in = S_MUL;
         S_MUL: st_in = big_ff ? S_PRE : S_SQRT;
         S_SQRT: if (sqi_ff == 5'd25) st_in = S_PRE;
         S_PRE: st_in = (arrive_clr) ? S_IDLE : S_ROT;
         S_ROT: if (it_ff == SW'(Steps)) st_in = pass_ff ? S_ERR : S_PRE;
         S_ERR: if (!(err_ff > AngPi) && !(err_ff < -AngPi)) st_in = S_RATE;
         S_RATE: st_in = S_OUT;
         S_OUT: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         S_IDLE: begin
            pass_ff <= 1'b0;
            if (j_valid && j_ready) begin
               job_ff <= j_job;
               rsp_ff <= j_job.imm;
               big_ff <= ax >= 33'h1000000 || ay >= 33'h1000000;
            end
         end
         S_MUL: begin
            sq_ff <= 50'(bx[24:0]) * 50'(bx[24:0]) + 50'(by[24:0]) * 50'(by[24:0]);
            rem_ff <= '0;
            root_ff <= '0;
            sqi_ff <= '0;
            dist_ff <= SpeedMax;
         end
         S_SQRT: begin
            if (sqi_ff == 5'd25) begin
               dist_ff <= root_ff[24] ? SpeedMax : root_ff[23:0];
            end else begin
               if (!trial[49]) begin
                  rem_ff <= trial;
                  root_ff <= {root_ff[23:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[47:0], sq_ff[49:48]};
                  root_ff <= {root_ff[23:0], 1'b0};
               end
               sq_ff <= {sq_ff[47:0], 2'b00};
               sqi_ff <= sqi_ff + 5'd1;
            end
         end
         S_PRE: begin
            logic signed [VW-1:0] px, py;
            px = pass_ff ? yx : VW'(job_ff.dx);
            py = pass_ff ? yy : VW'(job_ff.dy);
            it_ff <= '0;
            if (px == 0 && py == 0) begin
               x_ff <= '0; y_ff <= '0; z_ff <= '0;
               it_ff <= SW'(Steps);
            end else if (px < 0 && py >= 0) begin
               x_ff <= py; y_ff <= -px; z_ff <= AngHalfPi;
            end else if (px < 0) begin
               x_ff <= -py; y_ff <= px; z_ff <= -AngHalfPi;
            end else begin
               x_ff <= px; y_ff <= py; z_ff <= '0;
            end
         end
         S_ROT: begin
            if (it_ff == SW'(Steps)) begin
               if (!pass_ff) tgt_ff <= z_ff;
               else err_ff <= tgt_ff - z_ff;
               pass_ff <= 1'b1;
            end else begin
               if (y_ff > 0) begin
                  x_ff <= x_ff + ys; y_ff <= y_ff - xs;
                  z_ff <= z_ff + atan_entry(5'(it_ff));
               end else begin
                  x_ff <= x_ff - ys; y_ff <= y_ff + xs;
                  z_ff <= z_ff - atan_entry(5'(it_ff));
               end
               it_ff <= it_ff + SW'(1);
            end
         end
         S_ERR: begin
            if (err_ff > AngPi) err_ff <= err_ff - AngTwoPi;
            else if (err_ff < -AngPi) err_ff <= err_ff + AngTwoPi;
            else prod_ff <= $signed({1'b0, heading_gain}) * err_ff;
         end
         S_RATE: begin
            rsp_ff.drive_valid <= 1'b1;
            rsp_ff.navigating <= 1'b1;
            rsp_ff.linear_speed <= (dist_ff < speed_cap) ? dist_ff : speed_cap;
            if (rnd > 57'sd32767) rsp_ff.angular_rate <= 16'sh7FFF;
            else if (rnd < -57'sd32768) rsp_ff.angular_rate <= 16'sh8000;
            else rsp_ff.angular_rate <= 16'(rnd);
         end
         default: ;
      endcase
      if (arrive_clr) rsp_ff <= '{drive_valid: 1'b1, linear_speed: '0,
                                  angular_rate: '0, navigating: 1'b0};
   end
endmodule

// ===== design/go_to_goal_heading_controller_top.sv =====
`timescale 1ns / 1ps
// channel | dir | handshake        | payload
// req     | in  | req_valid/ready  | cmd, pose, quaternion, target
// rsp     | out | rsp_valid/ready  | drive_valid, linear_speed, angular_rate, navigating
// csr     | in  | csr_we           | csr_index, csr_wdata (24 bits)
// Set goal/start/stop: queued in the front FIFO, then registered into rsp_valid.
// Tick: multiply, sqrt, CORDIC on target then yaw, heading wrap (repeats per wrap),
// scale, output; arrival ends it before CORDIC runs; a far goal skips the sqrt.
// Reset is synchronous, clears flags, queue and controller.
// Input stalls while a tick is in flight; rsp stall holds the back end.
module go_to_goal_heading_controller_top #(
   parameter int CORDIC_STEPS = gtg_pkg::CordicStepsDefault
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [1:0] req_cmd,
   input logic signed [31:0] req_pose_x,
   input logic signed [31:0] req_pose_y,
   input logic signed [15:0] req_quat_x,
   input logic signed [15:0] req_quat_y,
   input logic signed [15:0] req_quat_z,
   input logic signed [15:0] req_quat_w,
   input logic signed [31:0] req_target_x,
   input logic signed [31:0] req_target_y,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic rsp_drive_valid,
   output logic [23:0] rsp_linear_speed,
   output logic signed [15:0] rsp_angular_rate,
   output logic rsp_navigating,
   input logic csr_we,
   input logic [1:0] csr_index,
   input logic [23:0] csr_wdata
);
   import gtg_pkg::*;
   logic [23:0] speed_cap_ff, arrive_ff;
   logic [15:0] gain_ff;
   logic arrive_clr;
   logic tick_done;
   gtg_if #(.T(job_type)) jq ();
   gtg_if #(.T(rsp_type)) rq ();

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_cap_ff <= SpeedCapRst;
         arrive_ff <= ArriveRst;
         gain_ff <= GainRst;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_SPEED_CAP: speed_cap_ff <= csr_wdata;
            CSR_ARRIVE: arrive_ff <= csr_wdata;
            CSR_GAIN: gain_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   gtg_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_cmd(req_cmd),
      .in_pose_x(req_pose_x), .in_pose_y(req_pose_y),
      .in_qx(req_quat_x), .in_qy(req_quat_y), .in_qz(req_quat_z), .in_qw(req_quat_w),
      .in_tx(req_target_x), .in_ty(req_target_y),
      .q_valid(jq.valid), .q_ready(jq.ready), .q_job(jq.data), .arrive_clr(arrive_clr),
      .tick_done(tick_done)
   );

   gtg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset,
      .j_valid(jq.valid), .j_ready(jq.ready), .j_job(jq.data),
      .speed_cap(speed_cap_ff), .arrive_radius(arrive_ff), .heading_gain(gain_ff),
      .arrive_clr(arrive_clr), .tick_done(tick_done),
      .o_valid(rq.valid), .o_ready(rq.ready), .o_rsp(rq.data)
   );

   assign rq.ready = rsp_ready;
   assign rsp_valid = rq.valid;
   assign rsp_drive_valid = rq.data.drive_valid;
   assign rsp_linear_speed = rq.data.linear_speed;
   assign rsp_angular_rate = rq.data.angular_rate;
   assign rsp_navigating = rq.data.navigating;

   a_idle_nav: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_valid && !rsp_navigating |-> rsp_linear_speed == 24'd0)
      else $error("stop result with nonzero speed");
   a_speed_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_linear_speed <= speed_cap_ff)
      else $error("speed above limit");
   a_info_nodrive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_drive_valid |-> rsp_navigating && rsp_angular_rate == 16'sd0)
      else $error("bad status result");
endmodule
